>>> rtl/midi_noteoff_delay_scheduler_defines.svh
// ----------------------------------------------------------------------------
// MIDI note-off delay scheduler assertion macros
// Shared concurrent assertion forms for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTEOFF_DELAY_SCHEDULER_DEFINES_SVH
`define MIDI_NOTEOFF_DELAY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MNDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// Next-cycle implication, checked outside reset.
`define MNDS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

>>> rtl/mnds_pkg.sv
// ----------------------------------------------------------------------------
// MIDI note-off delay scheduler package
// Entry layout, compare result bundle and shared constants.
// ----------------------------------------------------------------------------
package mnds_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int MAX_RESULTS     = 64;
   localparam int RESULT_CNT_W    = $clog2(MAX_RESULTS + 1);

   localparam int TIME_W   = 32;
   localparam int OFFSET_W = 14;
   localparam int OUT_OFFSET_W = 13;
   localparam int DELAY_W  = 24;

   localparam logic [7:0] STATUS_CMD_MASK = 8'hF0;
   localparam logic [7:0] CMD_NOTEOFF     = 8'h80;
   localparam logic [7:0] CMD_NOTEON      = 8'h90;

   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // One stored event: 58 bits.
   typedef struct packed {
      logic [TIME_W-1:0] time_val;
      logic [7:0]        b0;
      logic [7:0]        b1;
      logic [7:0]        b2;
      logic [1:0]        len;
   } entry_type;

   // Results of the shared time compare unit.
   typedef struct packed {
      logic lo_ge;   // entry time >= low key
      logic lo_gt;   // entry time >  low key
      logic hi_lt;   // entry time <  high key
   } cmp_type;

endpackage

>>> rtl/midi_noteoff_delay_scheduler.sv
// ----------------------------------------------------------------------------
// MIDI note-off delay scheduler
// Time-sorted event store with note-off delay and per-period flush.
// ----------------------------------------------------------------------------
// A request on the req_ channel is either a MIDI event (req_op = 0) or an
// end-of-period flush (req_op = 1). Events are stored sorted by 32-bit frame
// time; while rolling, note-offs get csr_wr_data frames of delay. A flush
// returns, on the rsp_ channel, the head events inside the window, at most
// MAX_RESULTS of them, in time order, with rsp_last set on the final one.
// An event request never returns anything.
// The store is a circular buffer in one RAM. An insert walks from the tail
// toward the head, moving each later entry up one slot per cycle through the
// single time compare unit. Each flushed event takes a RAM read, a compare
// and a hand-off to the result register. req_stall stays high from
// acceptance until the sequencer is back at rest. The result register
// decouples the two sides: a stalled response only holds the flush at its
// next emission, and the last result may wait while the next request is
// taken.
// Reset empties the store and clears the delay; there is no clearing pass,
// so requests are taken as soon as reset is released.
// ----------------------------------------------------------------------------
`include "midi_noteoff_delay_scheduler_defines.svh"

module midi_noteoff_delay_scheduler #(
   parameter int QUEUE_DEPTH = mnds_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_frame_start,
   input  logic [13:0] req_offset,
   input  logic        req_rolling,
   input  logic [7:0]  req_status,
   input  logic [7:0]  req_data1,
   input  logic [7:0]  req_data2,
   input  logic [1:0]  req_length,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_out_offset,
   output logic [7:0]  rsp_out_status,
   output logic [7:0]  rsp_out_data1,
   output logic [7:0]  rsp_out_data2,
   output logic [1:0]  rsp_out_length,
   output logic        rsp_last,

   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int NW = mnds_pkg::RESULT_CNT_W;
   localparam int TW = mnds_pkg::TIME_W;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_INS_ADD = 7'b0000010,
      S_INS_CMP = 7'b0000100,
      S_INS_PUT = 7'b0001000,
      S_FL_RD   = 7'b0010000,
      S_FL_CMP  = 7'b0100000,
      S_FL_EMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [mnds_pkg::DELAY_W-1:0] delay_ff, delay_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] j_ff, j_in;
   logic [NW-1:0] n_ff, n_in;
   logic          pend_ff, pend_in;
   logic          last_ff, last_in;
   logic          delay_en_ff, delay_en_in;
   logic [TW-1:0] start_ff, start_in;
   logic [TW-1:0] end_ff, end_in;
   mnds_pkg::entry_type new_ff, new_in;
   mnds_pkg::entry_type pend_ent_ff, pend_ent_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [12:0]   rsp_offset_ff, rsp_offset_in;
   logic [7:0]    rsp_status_ff, rsp_status_in;
   logic [7:0]    rsp_data1_ff, rsp_data1_in;
   logic [7:0]    rsp_data2_ff, rsp_data2_in;
   logic [1:0]    rsp_length_ff, rsp_length_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          req_acc;
   logic          out_free;
   logic          out_load;
   logic          ram_we;
   logic          ram_re;
   logic [CW-1:0] rd_l;
   logic [CW-1:0] wr_l;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   mnds_pkg::entry_type ram_wr_data;
   logic [$bits(mnds_pkg::entry_type)-1:0] ram_rd_raw;
   mnds_pkg::entry_type rd_ent;
   logic [AW-1:0] head_next;
   logic [TW-1:0] key_lo;
   mnds_pkg::cmp_type cmp;
   logic          in_window;
   logic          is_noteoff;
   logic [7:0]    cmd;
   logic [TW-1:0] rel_time;

   // ------------------------------------------------------------------------
   // Storage, address mapping and the shared compare unit
   // ------------------------------------------------------------------------
   mnds_ram #(
      .WIDTH ($bits(mnds_pkg::entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_raw)
   );

   mnds_addr #(.DEPTH(QUEUE_DEPTH)) u_rd_addr (
      .head (head_ff),
      .lidx (rd_l),
      .phys (rd_addr)
   );

   mnds_addr #(.DEPTH(QUEUE_DEPTH)) u_wr_addr (
      .head (head_ff),
      .lidx (wr_l),
      .phys (wr_addr)
   );

   assign rd_ent = mnds_pkg::entry_type'(ram_rd_raw);

   // During an insert the low key is the new event time; during a flush it
   // is the window start and the high key is the window end.
   assign key_lo = (state_ff == S_INS_CMP) ? new_ff.time_val : start_ff;

   mnds_cmp u_cmp (
      .entry_time (rd_ent.time_val),
      .key_lo     (key_lo),
      .key_hi     (end_ff),
      .result     (cmp)
   );

   assign in_window = cmp.lo_ge && cmp.hi_lt;

   // ------------------------------------------------------------------------
   // Handshake helpers
   // ------------------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign head_next = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);

   // Note-offs, and note-ons with zero velocity, are delayed while rolling.
   assign cmd = req_status & mnds_pkg::STATUS_CMD_MASK;
   assign is_noteoff = (cmd == mnds_pkg::CMD_NOTEOFF) ||
                       ((cmd == mnds_pkg::CMD_NOTEON) && (req_data2 == 8'd0));

   assign rel_time = pend_ent_ff.time_val - start_ff;

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      delay_in    = delay_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      j_in        = j_ff;
      n_in        = n_ff;
      pend_in     = pend_ff;
      last_in     = last_ff;
      delay_en_in = delay_en_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      new_in      = new_ff;
      pend_ent_in = pend_ent_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      rd_l        = '0;
      wr_l        = j_ff;
      ram_wr_data = new_ff;
      out_load    = 1'b0;

      if (csr_wr_en) begin
         delay_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               start_in = req_frame_start;
               end_in   = req_frame_start + TW'(req_offset);
               if (req_op == mnds_pkg::OP_FLUSH) begin
                  n_in     = '0;
                  pend_in  = 1'b0;
                  state_in = S_FL_RD;
               end else begin
                  delay_en_in     = req_rolling && is_noteoff;
                  new_in.time_val = '0;
                  new_in.b0       = req_status;
                  new_in.b1       = (req_length >= 2'd2) ? req_data1 : 8'd0;
                  new_in.b2       = (req_length == 2'd3) ? req_data2 : 8'd0;
                  new_in.len      = req_length;
                  state_in        = S_INS_ADD;
               end
            end
         end

         S_INS_ADD: begin
            new_in.time_val = end_ff + (delay_en_ff ? TW'(delay_ff) : '0);
            if (count_ff >= CW'(QUEUE_DEPTH)) begin
               // Full store: the event is dropped.
               state_in = S_IDLE;
            end else if (count_ff == '0) begin
               j_in     = '0;
               state_in = S_INS_PUT;
            end else begin
               ram_re   = 1'b1;
               rd_l     = count_ff - CW'(1);
               j_in     = count_ff;
               state_in = S_INS_CMP;
            end
         end

         S_INS_CMP: begin
            // Data for position j-1 is on the RAM output.
            ram_we = 1'b1;
            wr_l   = j_ff;
            if (cmp.lo_gt) begin
               ram_wr_data = rd_ent;
               j_in        = j_ff - CW'(1);
               if (j_ff > CW'(1)) begin
                  ram_re = 1'b1;
                  rd_l   = j_ff - CW'(2);
               end else begin
                  state_in = S_INS_PUT;
               end
            end else begin
               ram_wr_data = new_ff;
               count_in    = count_ff + CW'(1);
               state_in    = S_IDLE;
            end
         end

         S_INS_PUT: begin
            ram_we      = 1'b1;
            wr_l        = j_ff;
            ram_wr_data = new_ff;
            count_in    = count_ff + CW'(1);
            state_in    = S_IDLE;
         end

         S_FL_RD: begin
            if ((count_ff != '0) && (n_ff < NW'(mnds_pkg::MAX_RESULTS))) begin
               ram_re   = 1'b1;
               rd_l     = '0;
               state_in = S_FL_CMP;
            end else if (pend_ff) begin
               last_in  = 1'b1;
               state_in = S_FL_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_FL_CMP: begin
            if (in_window && !pend_ff) begin
               pend_ent_in = rd_ent;
               pend_in     = 1'b1;
               head_in     = head_next;
               count_in    = count_ff - CW'(1);
               n_in        = n_ff + NW'(1);
               state_in    = S_FL_RD;
            end else if (pend_ff) begin
               last_in  = !in_window;
               state_in = S_FL_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_FL_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               pend_in  = 1'b0;
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  // The next head is still on the RAM output and in window.
                  pend_ent_in = rd_ent;
                  pend_in     = 1'b1;
                  head_in     = head_next;
                  count_in    = count_ff - CW'(1);
                  n_in        = n_ff + NW'(1);
                  state_in    = S_FL_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data1_in  = rsp_data1_ff;
      rsp_data2_in  = rsp_data2_ff;
      rsp_length_in = rsp_length_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_offset_in = rel_time[mnds_pkg::OUT_OFFSET_W-1:0];
         rsp_status_in = pend_ent_ff.b0;
         rsp_data1_in  = pend_ent_ff.b1;
         rsp_data2_in  = pend_ent_ff.b2;
         rsp_length_in = pend_ent_ff.len;
         rsp_last_in   = last_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         delay_ff     <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
         pend_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         delay_ff     <= delay_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delay_en_ff   <= delay_en_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      new_ff        <= new_in;
      pend_ent_ff   <= pend_ent_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data1_ff  <= rsp_data1_in;
      rsp_data2_ff  <= rsp_data2_in;
      rsp_length_ff <= rsp_length_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_offset = rsp_offset_ff;
   assign rsp_out_status = rsp_status_ff;
   assign rsp_out_data1  = rsp_data1_ff;
   assign rsp_out_data2  = rsp_data2_ff;
   assign rsp_out_length = rsp_length_ff;
   assign rsp_last       = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `MNDS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(QUEUE_DEPTH))
   `MNDS_ASSERT_IMP(a_emit_has_entry, clock, reset, out_load, pend_ff)
   `MNDS_ASSERT_NXT(a_put_grows, clock, reset, state_ff == S_INS_PUT,
                    count_ff == $past(count_ff) + CW'(1))

endmodule

>>> rtl/mnds_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mnds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mnds_addr.sv
// ----------------------------------------------------------------------------
// Queue address map
// Turns a position counted from the queue head into a RAM address.
// ----------------------------------------------------------------------------
module mnds_addr #(
   parameter int DEPTH = 64
) (
   input  logic [$clog2(DEPTH)-1:0]   head,
   input  logic [$clog2(DEPTH+1)-1:0] lidx,
   output logic [$clog2(DEPTH)-1:0]   phys
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [SW-1:0] sum;

   // Head plus position stays below twice the depth, so one subtract wraps it.
   always_comb begin
      sum = SW'(head) + SW'(lidx);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      phys = sum[AW-1:0];
   end

endmodule

>>> rtl/mnds_cmp.sv
// ----------------------------------------------------------------------------
// Time compare unit
// Compares one stored entry time against a low and a high key.
// ----------------------------------------------------------------------------
module mnds_cmp (
   input  logic [mnds_pkg::TIME_W-1:0] entry_time,
   input  logic [mnds_pkg::TIME_W-1:0] key_lo,
   input  logic [mnds_pkg::TIME_W-1:0] key_hi,
   output mnds_pkg::cmp_type           result
);

   always_comb begin
      result.lo_ge = (entry_time >= key_lo);
      result.lo_gt = (entry_time >  key_lo);
      result.hi_lt = (entry_time <  key_hi);
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI note-off delay scheduler testbench
// Drives event and flush requests with random bursts and gaps. Response
// stalls follow a changing pattern. A time-sorted predictor of the event
// store checks every emitted event in order, field by field.
// ----------------------------------------------------------------------------
module tb;

   // Store size of the block as built, and the settling time after the last
   // request. An insert walks at most the whole store, so the block can
   // still be busy after the last expected event has come back.
   localparam int STORE_DEPTH   = mnds_pkg::QUEUE_DEPTH_DEF;
   localparam int SETTLE_CYCLES = STORE_DEPTH + 16;
   localparam int HOLD_CYCLES   = 800;
   localparam int STALL_LIMIT   = 5000;
   localparam int ITEM_TARGET   = 330;
   localparam int MAX_REPORTS   = 10;

   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
   localparam logic [13:0] SPAN_MAX = 14'h3FFF;
   localparam logic [23:0] DELAY_MAX = 24'hFF_FFFF;

   // A few status bytes outside the note-on/note-off family.
   localparam logic [7:0] ST_CONTROL = 8'hB0;
   localparam logic [7:0] ST_PROGRAM = 8'hC0;
   localparam logic [7:0] ST_CLOCK   = 8'hF8;
   localparam logic [7:0] ST_RESET   = 8'hFF;

   // One request as it appears on the req_ channel.
   typedef struct packed {
      logic        op;
      logic [31:0] frame_start;
      logic [13:0] offset;
      logic        rolling;
      logic [7:0]  status;
      logic [7:0]  data1;
      logic [7:0]  data2;
      logic [1:0]  length;
   } sched_req_t;

   // One emitted event as it appears on the rsp_ channel.
   typedef struct packed {
      logic [12:0] offset;
      logic [7:0]  status;
      logic [7:0]  data1;
      logic [7:0]  data2;
      logic [1:0]  length;
      logic        last;
   } note_out_t;

   // Every input of the block starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = mnds_pkg::OP_EVENT;
   logic [31:0] req_frame_start = '0;
   logic [13:0] req_offset = '0;
   logic        req_rolling = 1'b0;
   logic [7:0]  req_status = '0;
   logic [7:0]  req_data1 = '0;
   logic [7:0]  req_data2 = '0;
   logic [1:0]  req_length = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [12:0] rsp_out_offset;
   logic [7:0]  rsp_out_status;
   logic [7:0]  rsp_out_data1;
   logic [7:0]  rsp_out_data2;
   logic [1:0]  rsp_out_length;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [23:0] csr_wr_data = '0;

   // Requests waiting to be offered, the predicted store contents, the
   // events that the block still owes us, and the delay as last written.
   sched_req_t            req_backlog[$];
   mnds_pkg::entry_type   sched_store[$];
   note_out_t             due_events[$];
   logic [23:0]           note_off_delay;

   // Handshake flags as sampled at the last rising edge.
   bit req_fire;
   bit rsp_fire;

   int unsigned items_queued;
   int unsigned mismatches;
   int unsigned quiet_cycles;

   // Sender burst state and receiver stall state.
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned stall_mode;
   int unsigned mode_left;
   int unsigned hold_left;
   bit          hold_armed;

   midi_noteoff_delay_scheduler i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_frame_start(req_frame_start),
      .req_offset     (req_offset),
      .req_rolling    (req_rolling),
      .req_status     (req_status),
      .req_data1      (req_data1),
      .req_data2      (req_data2),
      .req_length     (req_length),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_offset (rsp_out_offset),
      .rsp_out_status (rsp_out_status),
      .rsp_out_data1  (rsp_out_data1),
      .rsp_out_data2  (rsp_out_data2),
      .rsp_out_length (rsp_out_length),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Inserts one event into the sorted store. Note-offs, and note-ons with a
   // zero velocity byte, are pushed back by the delay while the transport
   // rolls. The velocity test looks at data2 as given, even when the length
   // says that byte is not part of the event. Bytes past the length are
   // stored as zero. An event with the same time as stored ones goes behind
   // them, and a full store drops the new event.
   function automatic void schedule_event(sched_req_t r);
      mnds_pkg::entry_type e;
      logic [7:0]          cmd;
      logic [31:0]         lag;
      int                  pos;
      cmd = r.status & mnds_pkg::STATUS_CMD_MASK;
      lag = '0;
      if (r.rolling && (cmd == mnds_pkg::CMD_NOTEOFF ||
                        (cmd == mnds_pkg::CMD_NOTEON && r.data2 == 8'h00))) begin
         lag = {8'h00, note_off_delay};
      end
      e.time_val = r.frame_start + {18'h0, r.offset} + lag;
      e.b0       = r.status;
      e.b1       = (r.length >= 2'd2) ? r.data1 : 8'h00;
      e.b2       = (r.length == 2'd3) ? r.data2 : 8'h00;
      e.len      = r.length;
      if (sched_store.size() >= STORE_DEPTH) begin
         return;
      end
      pos = 0;
      while (pos < sched_store.size() && sched_store[pos].time_val <= e.time_val) begin
         pos++;
      end
      sched_store.insert(pos, e);
   endfunction

   // Pops head events while their time lies in [frame_start, frame_start +
   // offset). The compares are plain unsigned ones, so a window whose end
   // wraps past zero emits nothing, and the first head outside the window
   // ends the flush even if later entries would fit.
   function automatic void flush_window(sched_req_t r);
      logic [31:0] win_end;
      note_out_t   o;
      int          n;
      win_end = r.frame_start + {18'h0, r.offset};
      n = 0;
      while (n < mnds_pkg::MAX_RESULTS && sched_store.size() > 0 &&
             sched_store[0].time_val >= r.frame_start &&
             sched_store[0].time_val < win_end) begin
         o.offset = 13'(sched_store[0].time_val - r.frame_start);
         o.status = sched_store[0].b0;
         o.data1  = sched_store[0].b1;
         o.data2  = sched_store[0].b2;
         o.length = sched_store[0].len;
         o.last   = 1'b0;
         due_events.push_back(o);
         void'(sched_store.pop_front());
         n++;
      end
      if (n > 0) begin
         o = due_events.pop_back();
         o.last = 1'b1;
         due_events.push_back(o);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor, checker and watchdog, all on the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      sched_req_t seen;
      note_out_t  got;
      note_out_t  want;
      if (reset) begin
         req_fire = 1'b0;
         rsp_fire = 1'b0;
         sched_store.delete();
         due_events.delete();
         note_off_delay = '0;
         quiet_cycles = 0;
      end else begin
         req_fire = req_valid && !req_stall;
         rsp_fire = rsp_valid && !rsp_stall;
         if (csr_wr_en) begin
            note_off_delay = csr_wr_data;
         end
         if (rsp_fire) begin
            got = {rsp_out_offset, rsp_out_status, rsp_out_data1, rsp_out_data2,
                   rsp_out_length, rsp_last};
            if (due_events.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: unexpected event: offset %0d status %h data %h %h len %0d last %b",
                           $realtime, got.offset, got.status, got.data1, got.data2,
                           got.length, got.last);
               end
            end else begin
               want = due_events.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("%0t: event mismatch (expected / actual):", $realtime);
                     $display("   offset %0d / %0d, status %h / %h, data1 %h / %h",
                              want.offset, got.offset, want.status, got.status,
                              want.data1, got.data1);
                     $display("   data2 %h / %h, length %0d / %0d, last %b / %b",
                              want.data2, got.data2, want.length, got.length,
                              want.last, got.last);
                  end
               end
            end
         end
         if (req_fire) begin
            seen = {req_op, req_frame_start, req_offset, req_rolling, req_status,
                    req_data1, req_data2, req_length};
            if (seen.op == mnds_pkg::OP_FLUSH) begin
               flush_window(seen);
            end else begin
               schedule_event(seen);
            end
         end
         // The watchdog only looks for progress on some port. The longest
         // quiet stretch of a correct run is the receiver hold-off.
         if (req_fire || rsp_fire || csr_wr_en) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("%0t: no request or event moved for %0d cycles", $realtime,
                        STALL_LIMIT);
               $display("== FAIL ==");
               $finish;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps in between.
   // A request that is not taken stays on the port unchanged.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : driver
      sched_req_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_valid || req_fire) begin
         if (req_fire && burst_left > 0) begin
            burst_left--;
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         end
         if (gap_left > 0 || req_backlog.size() == 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end
            req_valid <= 1'b0;
         end else begin
            nxt = req_backlog.pop_front();
            req_valid       <= 1'b1;
            req_op          <= nxt.op;
            req_frame_start <= nxt.frame_start;
            req_offset      <= nxt.offset;
            req_rolling     <= nxt.rolling;
            req_status      <= nxt.status;
            req_data1       <= nxt.data1;
            req_data2       <= nxt.data2;
            req_length      <= nxt.length;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response stall pattern. The stall mode is drawn anew at random times,
   // from never stalling to stalling most of the time. When armed, the
   // receiver holds off for a long stretch starting at the next event it
   // sees, so the block backs up and stalls its request side.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode = 0;
         mode_left = 0;
         hold_left = 0;
      end else begin
         if (hold_armed && rsp_valid && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_armed = 1'b0;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(8, 64);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: begin
                  rsp_stall <= 1'b0;
               end
               1: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               2: begin
                  rsp_stall <= ($urandom_range(0, 1) == 0);
               end
               default: begin
                  rsp_stall <= ($urandom_range(0, 3) != 0);
               end
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic sched_req_t midi_event(logic [31:0] start, logic [13:0] offs,
                                             logic roll, logic [7:0] st,
                                             logic [7:0] d1, logic [7:0] d2,
                                             logic [1:0] len);
      sched_req_t r;
      r = {mnds_pkg::OP_EVENT, start, offs, roll, st, d1, d2, len};
      return r;
   endfunction

   // Flush requests still carry random bytes in the event fields; the block
   // must ignore them.
   function automatic sched_req_t period_flush(logic [31:0] start, logic [13:0] span);
      sched_req_t r;
      r = $urandom;
      r.op = mnds_pkg::OP_FLUSH;
      r.frame_start = start;
      r.offset = span;
      return r;
   endfunction

   // Mostly note-offs and note-ons, with a zero velocity a quarter of the
   // time, and the occasional short event.
   function automatic sched_req_t random_event(logic [31:0] start, logic [13:0] offs);
      logic [7:0] st;
      logic [7:0] d2;
      logic [1:0] len;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: st = mnds_pkg::CMD_NOTEOFF | 8'($urandom_range(0, 15));
         4, 5, 6:    st = mnds_pkg::CMD_NOTEON | 8'($urandom_range(0, 15));
         default:    st = 8'($urandom);
      endcase
      d2 = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      len = ($urandom_range(0, 7) < 5) ? 2'd3 : 2'($urandom_range(0, 2));
      return midi_event(start, offs, 1'($urandom), st, 8'($urandom), d2, len);
   endfunction

   task automatic queue_request(sched_req_t r);
      req_backlog.push_back(r);
      items_queued++;
   endtask

   // Waits until every request is taken and every predicted event has come
   // back, then gives a pending insert time to finish. Returns on a rising
   // edge, so new requests never race the driver.
   task automatic wait_quiet();
      while (req_backlog.size() != 0 || req_valid || due_events.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_delay(logic [23:0] frames);
      wait_quiet();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= frames;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // Empties the store by flushing a window that starts at the current head.
   // An entry at the very last frame time can never fall inside a window,
   // so such entries stay behind for good.
   task automatic drain_store();
      logic [31:0] head;
      logic [13:0] span;
      forever begin
         wait_quiet();
         if (sched_store.size() == 0) begin
            break;
         end
         head = sched_store[0].time_val;
         if (head == TIME_MAX) begin
            break;
         end
         span = (head > TIME_MAX - 32'(SPAN_MAX)) ? 14'(~head) : SPAN_MAX;
         queue_request(period_flush(head, span));
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : sequencer
      logic [31:0] now_frame;
      logic [13:0] span;
      logic [13:0] offs;
      int unsigned phase;
      int unsigned periods;
      int unsigned events;
      sched_req_t  noise;

      items_queued = 0;
      mismatches = 0;
      hold_armed = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with a delay of 256 frames.
      set_delay(24'd256);
      // Note-off and zero-velocity note-on while rolling are delayed; a
      // note-on with velocity and a note-off while stopped are not.
      queue_request(midi_event(32'd1000, 14'd5, 1'b1, mnds_pkg::CMD_NOTEOFF, 8'd60,
                               8'd64, 2'd3));
      queue_request(midi_event(32'd1000, 14'd10, 1'b1, mnds_pkg::CMD_NOTEON | 8'h3,
                               8'd61, 8'd0, 2'd3));
      queue_request(midi_event(32'd1000, 14'd10, 1'b1, mnds_pkg::CMD_NOTEON | 8'h3,
                               8'd62, 8'd100, 2'd3));
      queue_request(midi_event(32'd1000, 14'd20, 1'b0, mnds_pkg::CMD_NOTEOFF | 8'hF,
                               8'd63, 8'd0, 2'd3));
      // Single-byte event: both data bytes must come back as zero.
      queue_request(midi_event(32'd1000, 14'd20, 1'b1, ST_CLOCK, 8'hAA, 8'hBB, 2'd1));
      // Zero length is stored as such, with both data bytes cleared.
      queue_request(midi_event(32'd1000, 14'd30, 1'b1, mnds_pkg::CMD_NOTEOFF | 8'h5,
                               8'h11, 8'h22, 2'd0));
      // Two-byte note-on: the velocity test uses the data2 field as given.
      queue_request(midi_event(32'd1000, 14'd40, 1'b1, mnds_pkg::CMD_NOTEON | 8'h7,
                               8'h33, 8'h00, 2'd2));
      queue_request(midi_event(32'd1000, 14'd40, 1'b1, mnds_pkg::CMD_NOTEON | 8'h7,
                               8'h34, 8'h05, 2'd2));
      // Same time as an earlier event, so it must come out behind it.
      queue_request(midi_event(32'd1000, 14'd10, 1'b0, ST_CONTROL, 8'd7, 8'd127, 2'd3));
      queue_request(period_flush(32'd1000, 14'd8192));
      // Empty window on an empty store.
      queue_request(period_flush(32'd0, 14'd0));
      // Period longer than 8191 frames: offsets wrap to 13 bits.
      queue_request(midi_event(32'd20000, 14'd9000, 1'b0, mnds_pkg::CMD_NOTEON, 8'd60,
                               8'd100, 2'd3));
      queue_request(midi_event(32'd20000, 14'd16000, 1'b0, ST_PROGRAM, 8'd12, 8'd0,
                               2'd2));
      queue_request(midi_event(32'd20000, SPAN_MAX, 1'b1, mnds_pkg::CMD_NOTEOFF, 8'hFF,
                               8'hFF, 2'd3));
      queue_request(period_flush(32'd20000, SPAN_MAX));
      // Window whose end wraps past zero emits nothing.
      queue_request(midi_event(32'hFFFF_FF00, 14'h10, 1'b0, ST_PROGRAM, 8'd3, 8'd0,
                               2'd2));
      queue_request(period_flush(32'hFFFF_FF00, 14'h200));
      // A head before the window blocks everything behind it.
      queue_request(midi_event(32'd50, 14'd0, 1'b0, mnds_pkg::CMD_NOTEOFF, 8'd0, 8'd0,
                               2'd3));
      queue_request(midi_event(32'd5000, 14'd0, 1'b0, mnds_pkg::CMD_NOTEON, 8'd1, 8'd1,
                               2'd3));
      queue_request(period_flush(32'd100, 14'd10000));
      // Last frame time; this entry stays in the store for the whole run.
      queue_request(midi_event(TIME_MAX, 14'd0, 1'b0, ST_RESET, 8'hFF, 8'hFF, 2'd3));
      drain_store();

      // Back-pressure: more events than the store holds, then a flush whose
      // events the receiver sits on while the next period keeps coming.
      set_delay(24'd0);
      for (int i = 0; i < 70; i++) begin
         queue_request(random_event(32'd5000, 14'($urandom_range(0, 1999))));
      end
      hold_armed = 1'b1;
      queue_request(period_flush(32'd5000, 14'd2000));
      for (int i = 0; i < 12; i++) begin
         queue_request(random_event(32'd7000, 14'($urandom_range(0, 999))));
      end
      queue_request(period_flush(32'd7000, 14'd1000));
      drain_store();

      // Random periods. Each phase runs a string of periods with events
      // placed inside them, closed by a flush, with some noise requests and
      // the odd missing flush mixed in.
      phase = 0;
      while (items_queued < ITEM_TARGET) begin
         case (phase % 4)
            0:       set_delay(DELAY_MAX);
            1:       set_delay(24'd0);
            2:       set_delay(24'($urandom_range(1, 2000)));
            default: set_delay(24'($urandom));
         endcase
         case ($urandom_range(0, 2))
            0:       now_frame = $urandom_range(0, 1000);
            1:       now_frame = $urandom;
            default: now_frame = TIME_MAX - $urandom_range(0, 20000);
         endcase
         periods = $urandom_range(4, 10);
         for (int p = 0; p < periods; p++) begin
            span = ($urandom_range(0, 9) == 0) ? 14'($urandom_range(8192, 16383))
                                               : 14'($urandom_range(32, 600));
            events = $urandom_range(0, 6);
            for (int e = 0; e < events; e++) begin
               if ($urandom_range(0, 9) == 0) begin
                  noise = $urandom;
                  noise.frame_start = $urandom;
                  noise.offset = 14'($urandom_range(0, 16383));
                  queue_request(noise);
               end else begin
                  offs = ($urandom_range(0, 9) == 0) ? 14'($urandom_range(0, 16383))
                                                     : 14'($urandom_range(0, span - 1));
                  queue_request(random_event(now_frame, offs));
               end
            end
            if ($urandom_range(0, 7) != 0) begin
               queue_request(period_flush(now_frame, span));
            end
            now_frame = now_frame + 32'(span);
         end
         drain_store();
         phase++;
      end

      wait_quiet();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
